/* src/cas_pkg.sv */
`timescale 1ns / 1ps

package cas_pkg;

    // grid geometry
    localparam int ROW_W      = 64;
    localparam int MAX_WIDTH  = 64;
    localparam int WIDTH_W    = 7;
    localparam int HEIGHT_W   = 12;
    localparam int PASS_W     = 4;
    localparam int NBR_W      = 4;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GRID_WIDTH    = 2'd0,
        REG_GRID_HEIGHT   = 2'd1,
        REG_PILLAR_PASSES = 2'd2
    } cfg_reg_t;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(64);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(64);
    localparam logic [PASS_W-1:0]   PILLAR_RESET = PASS_W'(2);

    localparam logic [WIDTH_W-1:0]  MIN_WIDTH    = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH_V  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = HEIGHT_W'(3);
    localparam logic [PASS_W-1:0]   PASS_MAX     = '1;

    // automaton rule thresholds on the neighbor wall count
    localparam logic [NBR_W-1:0]    WALL_MIN     = NBR_W'(5);
    localparam logic [NBR_W-1:0]    PILLAR_MAX   = NBR_W'(1);

    // output queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam int OUT_TDATA_W = ((ROW_W + HEIGHT_W + 7) / 8) * 8;

    typedef struct packed {
        logic                frame_last;
        logic [HEIGHT_W-1:0] out_row;
        logic [ROW_W-1:0]    out_cells;
    } res_t;

    // one accepted row with the window it needs, handed to the lane array
    typedef struct packed {
        logic [ROW_W-1:0]    upper;
        logic [ROW_W-1:0]    middle;
        logic [ROW_W-1:0]    lower;
        logic [WIDTH_W-1:0]  width;
        logic                seed;
        logic                first_out;
        logic                last;
        logic [HEIGHT_W-1:0] row_idx;
    } stage_t;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        r = w;
        if (w < MIN_WIDTH)
            r = MIN_WIDTH;
        else if (w > MAX_WIDTH_V)
            r = MAX_WIDTH_V;
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [ROW_W-1:0] m;
        for (int i = 0; i < ROW_W; i++)
            m[i] = (WIDTH_W'(i) < w);
        return m;
    endfunction

endpackage

/* src/cas_lane.sv */
`timescale 1ns / 1ps

module cas_lane (
    input  logic [7:0] nbr,
    input  logic       mid,
    input  logic       active,
    input  logic       seed,
    output logic       cell_out
);
    import cas_pkg::*;

    logic [NBR_W-1:0] cnt;
    logic             wall;

    always_comb begin
        cnt = '0;
        for (int i = 0; i < 8; i++)
            cnt = cnt + NBR_W'(nbr[i]);
        wall     = (cnt >= WALL_MIN) || (seed && (cnt <= PILLAR_MAX));
        cell_out = active ? wall : mid;
    end

endmodule

/* src/cas_row_smooth.sv */
`timescale 1ns / 1ps

module cas_row_smooth (
    input  cas_pkg::stage_t st,
    output cas_pkg::res_t   res0,
    output cas_pkg::res_t   res1
);
    import cas_pkg::*;

    logic [ROW_W-1:0] lane_out;
    logic [ROW_W-1:0] smoothed;

    // edge columns never have a full neighborhood
    assign lane_out[0]         = st.middle[0];
    assign lane_out[ROW_W-1:MAX_WIDTH-1] = st.middle[ROW_W-1:MAX_WIDTH-1];

    for (genvar x = 1; x < MAX_WIDTH - 1; x++) begin : g_lane
        cas_lane u_lane (
            .nbr      ({st.upper[x-1], st.upper[x], st.upper[x+1],
                        st.middle[x-1], st.middle[x+1],
                        st.lower[x-1], st.lower[x], st.lower[x+1]}),
            .mid      (st.middle[x]),
            .active   ((WIDTH_W'(x) + WIDTH_W'(1)) < st.width),
            .seed     (st.seed),
            .cell_out (lane_out[x])
        );
    end

    assign smoothed = lane_out & width_mask(st.width);

    always_comb begin
        res0.out_cells  = st.first_out ? st.middle : smoothed;
        res0.out_row    = st.row_idx - HEIGHT_W'(1);
        res0.frame_last = 1'b0;
        res1.out_cells  = st.lower;
        res1.out_row    = st.row_idx;
        res1.frame_last = 1'b1;
    end

endmodule

/* src/cas_outq.sv */
`timescale 1ns / 1ps

module cas_outq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push0,
    input  logic                      push1,
    input  cas_pkg::res_t             din0,
    input  cas_pkg::res_t             din1,
    input  logic                      pop,
    output cas_pkg::res_t             dout,
    output logic                      not_empty,
    output logic [cas_pkg::OQ_CNT_W-1:0] count
);
    import cas_pkg::*;

    res_t                fifo_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0] count_reg, count_next;
    logic [OQ_CNT_W-1:0] push_cnt;
    logic                do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign push_cnt  = OQ_CNT_W'(push0) + OQ_CNT_W'(push1);
    assign dout      = fifo_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + OQ_PTR_W'(do_pop);
        count_next  = count_reg + push_cnt - OQ_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0)
            fifo_reg[wr_ptr_reg] <= din0;
        if (push1)
            fifo_reg[wr_ptr_reg + OQ_PTR_W'(push0)] <= din1;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue count above depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt != '0) |-> ({1'b0, count_reg} + {1'b0, push_cnt}
                              <= (OQ_CNT_W+1)'(OQ_DEPTH) + (OQ_CNT_W+1)'(do_pop)))
        else $error("output queue overflow");

    a_push1_needs_push0: assert property (@(posedge aclk) disable iff (!aresetn)
        push1 |-> push0)
        else $error("second result pushed without the first");

endmodule

/* src/cave_automaton_smoothing.sv */
`timescale 1ns / 1ps

// One smoothing pass of the 4-5 cave automaton, one grid row per cycle. Rows
// enter on s_ with new_map in s_tuser; a row is accepted every cycle while the
// 8-deep result queue has room for two more results beyond those of the row
// held in the smoothing stage. Each row is smoothed by
// a bank of per-cell lanes (8-neighbor wall count, cells outside the grid count
// as wall only through the unchanged border) and merged back into one row; the
// window is registered in the smoothing stage and the result is then written to
// the result queue. Row 0 of a pass gives no result; every later row gives the
// row above it; the last row of a pass also gives itself unchanged with m_tlast
// set, so a pass of H rows yields H results. Configuration writes go through
// cfg_ and take effect for the next accepted row; write them only while the
// block is idle.
module cave_automaton_smoothing (
    input  logic                           aclk,
    input  logic                           aresetn,
    // row_cells [63:0]
    input  logic [cas_pkg::ROW_W-1:0]      s_tdata,
    // new_map [0]
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // out_cells [63:0], out_row [75:64], zero [79:76]
    output logic [cas_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cas_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cas_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PASS_W-1:0]   pillar_reg;

    logic [ROW_W-1:0]    upper_reg, upper_next;
    logic [ROW_W-1:0]    middle_reg, middle_next;
    logic [HEIGHT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [PASS_W-1:0]   pass_cnt_reg, pass_cnt_next;
    logic                st_valid_reg, st_valid_next;
    stage_t              st_reg, st_next;

    logic                s_acc;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [HEIGHT_W-1:0] r_cur;
    logic [PASS_W-1:0]   pass_cur;
    logic [ROW_W-1:0]    row_in;
    logic                last_cur;

    res_t                res0, res1, q_head;
    logic                q_not_empty;
    logic [OQ_CNT_W-1:0] q_count;
    logic [OQ_CNT_W:0]   q_pending;

    // room for the row in the stage plus the one being accepted
    assign q_pending = {1'b0, q_count} + (st_valid_reg ? (OQ_CNT_W+1)'(2) : '0);
    assign s_tready  = (q_pending <= (OQ_CNT_W+1)'(OQ_DEPTH - 2));
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            pillar_reg <= PILLAR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_GRID_WIDTH:    width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_GRID_HEIGHT:   height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_PILLAR_PASSES: pillar_reg <= cfg_data[PASS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff    = clamp_width(width_reg);
        h_eff    = (height_reg < MIN_HEIGHT) ? MIN_HEIGHT : height_reg;
        r_cur    = s_tuser ? '0 : row_cnt_reg;
        pass_cur = s_tuser ? '0 : pass_cnt_reg;
        row_in   = s_tdata & width_mask(w_eff);
        last_cur = (r_cur != '0) && (r_cur >= h_eff - HEIGHT_W'(1));

        upper_next    = upper_reg;
        middle_next   = middle_reg;
        row_cnt_next  = row_cnt_reg;
        pass_cnt_next = pass_cnt_reg;
        st_valid_next = 1'b0;

        st_next.upper     = upper_reg;
        st_next.middle    = middle_reg;
        st_next.lower     = row_in;
        st_next.width     = w_eff;
        st_next.seed      = (pass_cur < pillar_reg);
        st_next.first_out = (r_cur == HEIGHT_W'(1));
        st_next.last      = last_cur;
        st_next.row_idx   = r_cur;

        if (s_acc) begin
            pass_cnt_next = pass_cur;
            middle_next   = row_in;
            if (r_cur == '0) begin
                upper_next   = '0;
                row_cnt_next = HEIGHT_W'(1);
            end else begin
                upper_next    = middle_reg;
                st_valid_next = 1'b1;
                if (last_cur) begin
                    row_cnt_next = '0;
                    if (pass_cur != PASS_MAX)
                        pass_cnt_next = pass_cur + PASS_W'(1);
                end else begin
                    row_cnt_next = r_cur + HEIGHT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg    <= '0;
            middle_reg   <= '0;
            row_cnt_reg  <= '0;
            pass_cnt_reg <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            upper_reg    <= upper_next;
            middle_reg   <= middle_next;
            row_cnt_reg  <= row_cnt_next;
            pass_cnt_reg <= pass_cnt_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc)
            st_reg <= st_next;
    end

    cas_row_smooth u_smooth (
        .st   (st_reg),
        .res0 (res0),
        .res1 (res1)
    );

    cas_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (st_valid_reg),
        .push1     (st_valid_reg && st_reg.last),
        .din0      (res0),
        .din1      (res1),
        .pop       (m_tready),
        .dout      (q_head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign m_tvalid = q_not_empty;
    assign m_tlast  = q_head.frame_last;
    assign m_tdata  = OUT_TDATA_W'({q_head.out_row, q_head.out_cells});

    a_stage_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (r_cur != '0)) |=> st_valid_reg)
        else $error("accepted row with a result left the stage empty");

    a_no_stage_on_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (r_cur == '0)) |=> !st_valid_reg)
        else $error("first row of a pass produced a result");

    a_wrap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && last_cur) |=> (row_cnt_reg == '0))
        else $error("row counter did not wrap after the last row");

    a_first_after_row0: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (r_cur == '0)) |=> (row_cnt_reg == HEIGHT_W'(1)) && (upper_reg == '0))
        else $error("window not restarted on the first row");

endmodule

/* tb/sv/cave_automaton_smoothing_tb.sv */
`timescale 1ns / 1ps

module cave_automaton_smoothing_tb;
    import cas_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;   // no register behind it
    localparam int HOLD_CYCLES   = 90;
    localparam int SETTLE_CYCLES = 16;
    localparam int STUCK_LIMIT   = 2000;

    typedef enum int {FILL_EVEN, FILL_DENSE, FILL_SPARSE, FILL_BLOCKY} fill_t;

    typedef struct packed {
        logic [ROW_W-1:0] cells;
        logic             new_map;
    } row_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic [ROW_W-1:0]       s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor copy of the registers and the row window
    logic [WIDTH_W-1:0]  reg_width   = WIDTH_RESET;
    logic [HEIGHT_W-1:0] reg_height  = HEIGHT_RESET;
    logic [PASS_W-1:0]   reg_pillars = PILLAR_RESET;
    logic [ROW_W-1:0]    row_above   = '0;
    logic [ROW_W-1:0]    row_mid     = '0;
    logic [HEIGHT_W-1:0] next_row_idx = '0;
    logic [PASS_W-1:0]   passes_done = '0;

    row_req_t pending_rows[$];
    res_t     expected_rows[$];

    int rows_queued   = 0;
    int rows_accepted = 0;
    int rows_checked  = 0;
    int reg_writes    = 0;
    int mismatches    = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int stuck_cycles  = 0;

    cave_automaton_smoothing DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic [ROW_W-1:0] cell_mask(input int w);
        return (w >= ROW_W) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [ROW_W-1:0] smooth_row(input logic [ROW_W-1:0] up,
                                                    input logic [ROW_W-1:0] mid,
                                                    input logic [ROW_W-1:0] low,
                                                    input int w, input logic seed);
        logic [ROW_W-1:0] res;
        int n;
        res = mid;
        for (int x = 1; x + 1 < w; x++) begin
            n = up[x-1] + up[x] + up[x+1] + mid[x-1] + mid[x+1]
              + low[x-1] + low[x] + low[x+1];
            res[x] = (n >= 5) || (seed && n <= 1);
        end
        return res & cell_mask(w);
    endfunction

    // advance the row window by one request and queue what it must emit
    task automatic model_row(input logic [ROW_W-1:0] cells, input logic fresh_map);
        int w;
        int h;
        logic [HEIGHT_W-1:0] r;
        logic [ROW_W-1:0] row;
        logic seed;
        res_t e;
        w = (reg_width < 3) ? 3 : (reg_width > MAX_WIDTH) ? MAX_WIDTH : int'(reg_width);
        h = (reg_height < 3) ? 3 : int'(reg_height);
        if (fresh_map) begin
            next_row_idx = '0;
            passes_done = '0;
        end
        r = next_row_idx;
        row = cells & cell_mask(w);
        seed = passes_done < reg_pillars;
        if (r == 0) begin
            row_above = '0;
            row_mid = row;
            next_row_idx = HEIGHT_W'(1);
        end else begin
            e.out_cells = (r == 1) ? row_mid : smooth_row(row_above, row_mid, row, w, seed);
            e.out_row = r - HEIGHT_W'(1);
            e.frame_last = 1'b0;
            expected_rows = {expected_rows, e};
            row_above = row_mid;
            row_mid = row;
            if (r >= h - 1) begin
                // last row also goes out as is
                e.out_cells = row;
                e.out_row = r;
                e.frame_last = 1'b1;
                expected_rows = {expected_rows, e};
                next_row_idx = '0;
                if (passes_done != PASS_MAX)
                    passes_done++;
            end else begin
                next_row_idx = r + HEIGHT_W'(1);
            end
        end
    endtask

    function automatic int idle_pct(input bit receiver);
        if (rows_accepted < 290)
            return receiver ? 47 : 30;
        if (rows_accepted < 580)
            return receiver ? 30 : 47;
        return 0;
    endfunction

    function automatic logic [ROW_W-1:0] random_cells(input fill_t style);
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        logic [ROW_W-1:0] res;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case (style)
            FILL_DENSE:  res = a | b;
            FILL_SPARSE: res = a & b;
            FILL_BLOCKY: begin
                case ($urandom_range(3))
                    0: res = '1;
                    1: res = '0;
                    default: res = a;
                endcase
            end
            default:     res = a;
        endcase
        return res;
    endfunction

    task automatic offer_row(input logic [ROW_W-1:0] cells, input logic fresh_map);
        row_req_t req;
        req.cells = cells;
        req.new_map = fresh_map;
        pending_rows = {pending_rows, req};
        rows_queued++;
    endtask

    task automatic queue_map(input int passes, input int rows_per_pass, input bit fresh,
                             input int noise_pct);
        fill_t style;
        bit nm;
        style = fill_t'($urandom_range(3));
        for (int p = 0; p < passes; p++) begin
            for (int r = 0; r < rows_per_pass; r++) begin
                // occasional stray new_map breaks the pass in the middle
                nm = (fresh && p == 0 && r == 0) || ($urandom_range(99) < noise_pct);
                offer_row(random_cells(style), nm);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == REG_GRID_WIDTH)
            reg_width = val[WIDTH_W-1:0];
        else if (idx == REG_GRID_HEIGHT)
            reg_height = val[HEIGHT_W-1:0];
        else if (idx == REG_PILLAR_PASSES)
            reg_pillars = val[PASS_W-1:0];
    endtask

    // all requests taken, all results back, then a pause for rows still in flight
    task automatic settle();
        while (rows_accepted != rows_queued || expected_rows.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_setting(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] pil, input int maps,
                               input int passes, input int rows, input int noise_pct);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_PILLAR_PASSES, pil);
        repeat (maps) queue_map(passes, rows, 1'b1, noise_pct);
        settle();
    endtask

    task automatic report(input string what, input logic [ROW_W-1:0] want,
                          input logic [ROW_W-1:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : row_driver
        row_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                model_row(s_tdata, s_tuser);
                rows_accepted++;
            end
            if (s_tvalid && !s_tready) begin
                // request still waiting, keep it on the bus
            end else if (pending_rows.size() != 0 &&
                         (hold_left > 0 || $urandom_range(99) >= idle_pct(1'b0))) begin
                nxt = pending_rows[0];
                pending_rows.delete(0);
                s_tdata <= nxt.cells;
                s_tuser <= nxt.new_map;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                rows_checked++;
                if (expected_rows.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, actual cells %h row %0d last %b",
                             $time, m_tdata[ROW_W-1:0], m_tdata[ROW_W +: HEIGHT_W], m_tlast);
                end else begin
                    want = expected_rows[0];
                    expected_rows.delete(0);
                    if (m_tdata[ROW_W-1:0] !== want.out_cells)
                        report("out_cells", want.out_cells, m_tdata[ROW_W-1:0]);
                    if (m_tdata[ROW_W +: HEIGHT_W] !== want.out_row)
                        report("out_row", ROW_W'(want.out_row),
                               ROW_W'(m_tdata[ROW_W +: HEIGHT_W]));
                    if (m_tlast !== want.frame_last)
                        report("frame_last", ROW_W'(want.frame_last), ROW_W'(m_tlast));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && pending_rows.size() > 40) begin
                // long back-pressure so the input side has to stall
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct(1'b1));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STUCK_LIMIT, expected_rows.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: 64 wide, 64 tall, restart in the middle of the pass
        offer_row('1, 1'b1);
        offer_row('0, 1'b0);
        offer_row(64'h5555_5555_5555_5555, 1'b0);
        offer_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        offer_row('1, 1'b0);
        offer_row(64'h8000_0000_0000_0001, 1'b0);
        offer_row('1, 1'b1);
        offer_row(64'h0123_4567_89AB_CDEF, 1'b0);
        settle();

        write_reg(REG_GRID_WIDTH, 12'd10);
        write_reg(REG_GRID_HEIGHT, 12'd4);
        write_reg(REG_PILLAR_PASSES, 12'd1);
        // pillar pass, then a plain pass, then two new maps, the first cut short
        offer_row('1, 1'b1);
        offer_row('0, 1'b0);
        offer_row(64'h5555_5555_5555_5555, 1'b0);
        offer_row('1, 1'b0);
        offer_row('0, 1'b0);
        offer_row('1, 1'b0);
        offer_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        offer_row(64'hFFFF_FFFF_FFFF_FC00, 1'b0);   // walls only above the width
        offer_row(64'h3FF, 1'b1);
        offer_row('0, 1'b0);
        offer_row(64'h2AA, 1'b1);
        offer_row('1, 1'b0);
        offer_row('0, 1'b0);
        offer_row(64'h155, 1'b0);
        settle();

        run_setting(12'd64, 12'd64, 12'd2, 1, 2, 64, 1);
        write_reg(REG_SPARE, 12'hABC);
        // upper bits of the write data are dropped; pass count runs into saturation
        run_setting(12'hF88, 12'd3, 12'hFFF, 1, 18, 3, 0);
        run_setting(12'd3, 12'd5, 12'd0, 2, 3, 5, 2);
        run_setting(12'd0, 12'd0, 12'd3, 2, 4, 3, 2);
        run_setting(12'd127, 12'd7, 12'd1, 2, 3, 7, 2);
        run_setting(12'd65, 12'd1, 12'd4, 1, 6, 3, 2);
        run_setting(12'd37, 12'd9, 12'd2, 3, 3, 9, 2);
        run_setting(12'd63, 12'd12, 12'd5, 2, 4, 12, 2);

        // tall grid left part way, then height dropped below the current row
        run_setting(12'd64, 12'd4095, 12'd7, 1, 1, 40, 0);
        write_reg(REG_GRID_HEIGHT, 12'd10);
        queue_map(1, 1, 1'b0, 0);
        queue_map(2, 10, 1'b0, 2);
        settle();

        run_setting(12'd20, 12'd6, 12'd2, 5, 4, 6, 2);
        run_setting(12'd64, 12'd32, 12'd1, 2, 2, 32, 2);

        while (rows_accepted != rows_queued || expected_rows.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d rows sent, %0d smoothed rows checked, %0d register writes",
                 rows_accepted, rows_checked, reg_writes);
        $display("covered widths 3..64 and clamped, heights 3..4095, pillar passes 0..15");
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
src/cas_pkg.sv
src/cas_lane.sv
src/cas_row_smooth.sv
src/cas_outq.sv
src/cave_automaton_smoothing.sv
tb/sv/cave_automaton_smoothing_tb.sv
